[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
// ASSERT_SYNC checks a property at every rising clock edge outside reset.
// ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: synchronous check");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: unconditional check");
`else
`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hdl/ucd_pkg.sv]
`default_nettype none

package ucd_pkg;

    // Stream widths.
    localparam int IN_W        = 46;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Result field widths.
    localparam int YEAR_W = 22;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    // Shifted time: the input plus the era offset always lands in [0, 2^47).
    localparam int SHIFT_W = 47;
    localparam logic [SHIFT_W-1:0] SEC_SHIFT = 47'd46387767571200;

    // Divisors. A day is 128 * 675 seconds, so days come from a shift and a divide by 675.
    localparam int unsigned DAY_LO_DIV  = 675;
    localparam int unsigned SEC_PER_MIN = 60;
    localparam int unsigned ERA_DAYS    = 146097;
    localparam int unsigned YEAR_MUL    = 2939745;
    localparam int unsigned DOY_DIV     = YEAR_MUL * 4;
    localparam int unsigned MONTH_DIV   = 2141;

    // Widths of intermediate values.
    localparam int QHI_W  = 11;
    localparam int QLO_W  = 20;
    localparam int DAYS_W = 30;
    localparam int SOD_W  = 17;
    localparam int CENT_W = 15;
    localparam int REM_W  = 18;
    localparam int MINS_W = 11;
    localparam int PY_W   = 40;
    localparam int YOC_W  = 7;
    localparam int DOY_W  = 9;
    localparam int N4_W   = 20;

    // Month and year constants.
    localparam logic [N4_W-1:0]   MONTH_MUL  = 20'd2141;
    localparam logic [N4_W-1:0]   MONTH_ADD  = 20'd197913;
    localparam logic [DOY_W-1:0]  MARCH_SPAN = 9'd306;
    localparam logic [YEAR_W-1:0] CENT_YEARS = 22'd100;
    localparam logic [YEAR_W-1:0] YEAR_BIAS  = 22'd1469900;
    localparam logic [MON_W-1:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY   = 5'd24;

    // Time of day.
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_tod;

    // Sideband carried through the day-of-year division.
    typedef struct packed {
        logic [YOC_W-1:0]  yoc;
        t_tod              tod;
        logic [CENT_W-1:0] cent;
    } t_y_side;

    // Sideband carried through the day-of-month division.
    typedef struct packed {
        logic [YEAR_W-1:0] year_shifted;
        logic              jan_feb;
        logic [MON_W-1:0]  mon_m;
        t_tod              tod;
    } t_m_side;

endpackage

`default_nettype wire

[hdl/ucd_cdiv.sv]
`default_nettype none

// Pipelined division by a constant: reciprocal multiply, back-multiply, one correction.
// Three register stages, one transfer per cycle unless the output stalls, sideband travels with the operand.
module ucd_cdiv #(
    parameter int unsigned XW      = 32,
    parameter int unsigned QW      = 16,
    parameter int unsigned SW      = 1,
    parameter int unsigned DIVISOR = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [XW-1:0]                i_x,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [QW-1:0]                o_q,
    output logic [$clog2(DIVISOR)-1:0]   o_r,
    output logic [SW-1:0]                o_side
);

`include "assert_macros.svh"

    localparam int RW = $clog2(DIVISOR);
    // Truncated reciprocal; the estimate it gives is the quotient or one less.
    localparam longint unsigned MFULL = (64'd1 << XW) / 64'(DIVISOR);
    localparam int MW = $clog2(MFULL + 64'd1);
    localparam int PW = XW + MW;
    localparam logic [MW-1:0] RECIP = MW'(MFULL);
    localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

    logic          r_v1, r_v2, r_v3;
    logic          w_ce1, w_ce2, w_ce3;
    logic [XW-1:0] r_x1, r_x2;
    logic [PW-1:0] r_p1, n_p1;
    logic [SW-1:0] r_s1, r_s2, r_s3;
    logic [QW-1:0] r_q2, n_q2, r_q3, n_q3;
    logic [XW-1:0] r_qd2, n_qd2;
    logic [RW-1:0] r_r3, n_r3;
    logic [XW-1:0] w_rest;
    logic          w_fix;

    // A stage takes a new item when it is empty or its content moves on.
    assign w_ce3   = !r_v3 || i_ready;
    assign w_ce2   = !r_v2 || w_ce3;
    assign w_ce1   = !r_v1 || w_ce2;
    assign o_ready = w_ce1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ce1) begin
                r_v1 <= i_valid;
            end
            if (w_ce2) begin
                r_v2 <= r_v1;
            end
            if (w_ce3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: multiply by the reciprocal.
    assign n_p1 = PW'(i_x) * PW'(RECIP);

    // Stage 2: quotient estimate and its product with the divisor.
    assign n_q2  = QW'(r_p1 >> XW);
    assign n_qd2 = XW'(n_q2) * DIV_X;

    // Stage 3: remainder and a single correction step.
    assign w_rest = r_x2 - r_qd2;
    assign w_fix  = (w_rest >= DIV_X);
    assign n_q3   = w_fix ? (r_q2 + QW'(1)) : r_q2;
    assign n_r3   = RW'(w_fix ? (w_rest - DIV_X) : w_rest);

    always_ff @(posedge i_clk) begin
        if (w_ce1) begin
            r_x1 <= i_x;
            r_p1 <= n_p1;
            r_s1 <= i_side;
        end
        if (w_ce2) begin
            r_x2  <= r_x1;
            r_q2  <= n_q2;
            r_qd2 <= n_qd2;
            r_s2  <= r_s1;
        end
        if (w_ce3) begin
            r_q3 <= n_q3;
            r_r3 <= n_r3;
            r_s3 <= r_s2;
        end
    end

    assign o_valid = r_v3;
    assign o_q     = r_q3;
    assign o_r     = r_r3;
    assign o_side  = r_s3;

    `ASSERT_SYNC(a_rem_in_range, i_clk, i_rst_n, r_v3 |-> (XW'(r_r3) < DIV_X))
    `ASSERT_SYNC(a_est_not_high, i_clk, i_rst_n, r_v2 |-> (r_qd2 <= r_x2))
    `ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !r_v3)

endmodule

`default_nettype wire

[hdl/unix_seconds_to_civil_datetime.sv]
// One timestamp per cycle unless the output stalls; seven chained constant dividers of three stages
// each plus four single-stage registers carry the work, every stage with its own valid.
// Reset (synchronous, active low) empties the pipeline; data registers keep their value.
// A stall on the output holds only the full stages; bubbles ahead of it still close up.
`default_nettype none

module unix_seconds_to_civil_datetime (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [45:0] unix_seconds, [47:46] zero
    input  logic [ucd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [21:0] years_since_1900, [25:22] month_index, [30:26] day_of_month,
    // [35:31] hour_of_day, [41:36] minute_of_hour, [47:42] second_of_minute
    output logic [ucd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    import ucd_pkg::*;

`include "assert_macros.svh"

    // Stage A: sign extension and era offset.
    logic               r_va, w_ce_a;
    logic [SHIFT_W-1:0] r_shifted, n_shifted;
    logic [IN_W-1:0]    w_in;

    // Divider handshakes and results.
    logic w_d1_ready, w_d1_valid, w_d2_ready, w_d2_valid, w_d3_ready, w_d3_valid;
    logic w_d4_ready, w_d4_valid, w_d5_ready, w_d5_valid, w_d6_ready, w_d6_valid;
    logic w_d7_ready, w_d7_valid;

    logic [QHI_W-1:0]                 w_d1_q;
    logic [$clog2(DAY_LO_DIV)-1:0]    w_d1_r;
    logic [26:0]                      w_d1_side;
    logic [QLO_W-1:0]                 w_d2_q;
    logic [$clog2(DAY_LO_DIV)-1:0]    w_d2_r;
    logic [QHI_W+6:0]                 w_d2_side;
    logic [DAYS_W-1:0]                w_days;
    logic [SOD_W-1:0]                 w_sod;
    logic [CENT_W-1:0]                w_d3_q;
    logic [REM_W-1:0]                 w_d3_r;
    logic [SOD_W-1:0]                 w_d3_side;
    logic [MINS_W-1:0]                w_d4_q;
    logic [SEC_W-1:0]                 w_d4_r;
    logic [CENT_W+REM_W-1:0]          w_d4_side;
    logic [HOUR_W-1:0]                w_d5_q;
    logic [MIN_W-1:0]                 w_d5_r;
    logic [SEC_W+CENT_W+REM_W-1:0]    w_d5_side;
    logic [DOY_W-1:0]                 w_d6_q;
    t_y_side                          w_d6_side_in, w_d6_side;
    logic [DAY_W-1:0]                 w_d7_q;
    t_m_side                          w_d7_side_in, w_d7_side;

    // Stage B: year-of-century product.
    logic              r_vb, w_ce_b;
    logic [PY_W-1:0]   r_py, n_py;
    logic [CENT_W-1:0] r_b_cent;
    t_tod              r_b_tod, n_b_tod;
    logic [REM_W-1:0]  w_b_rem;

    // Stage C: shifted year and month product.
    logic              r_vc, w_ce_c;
    logic [YEAR_W-1:0] r_c_ys, n_c_ys;
    logic              r_c_jf, n_c_jf;
    logic [N4_W-1:0]   r_c_n4, n_c_n4;
    t_tod              r_c_tod;

    // Output register.
    logic              r_vo, w_ce_o;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [MON_W-1:0]  r_mon, n_mon;
    logic [DAY_W-1:0]  r_day, n_day;
    t_tod              r_o_tod;

    // Stage A: the offset makes every input value non-negative.
    assign w_ce_a          = !r_va || w_d1_ready;
    assign o_s_axis_tready = w_ce_a;
    assign w_in            = i_s_axis_tdata[IN_W-1:0];
    assign n_shifted       = {w_in[IN_W-1], w_in} + SEC_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_ce_a) begin
            r_va <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce_a) begin
            r_shifted <= n_shifted;
        end
    end

    // Days: (shifted >> 7) / 675 as a two-digit long division, high 20 bits first.
    ucd_cdiv #(
        .XW(20), .QW(QHI_W), .SW(27), .DIVISOR(DAY_LO_DIV)
    ) u_div_day_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .o_ready (w_d1_ready),
        .i_x     (r_shifted[SHIFT_W-1:27]),
        .i_side  (r_shifted[26:0]),
        .o_valid (w_d1_valid),
        .i_ready (w_d2_ready),
        .o_q     (w_d1_q),
        .o_r     (w_d1_r),
        .o_side  (w_d1_side)
    );

    ucd_cdiv #(
        .XW(30), .QW(QLO_W), .SW(QHI_W + 7), .DIVISOR(DAY_LO_DIV)
    ) u_div_day_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_valid),
        .o_ready (w_d2_ready),
        .i_x     ({w_d1_r, w_d1_side[26:7]}),
        .i_side  ({w_d1_q, w_d1_side[6:0]}),
        .o_valid (w_d2_valid),
        .i_ready (w_d3_ready),
        .o_q     (w_d2_q),
        .o_r     (w_d2_r),
        .o_side  (w_d2_side)
    );

    assign w_days = DAYS_W'({w_d2_side[QHI_W+6:7], w_d2_q});
    assign w_sod  = {w_d2_r, w_d2_side[6:0]};

    // Century and day within the century from 4 * days + 3.
    ucd_cdiv #(
        .XW(32), .QW(CENT_W), .SW(SOD_W), .DIVISOR(ERA_DAYS)
    ) u_div_cent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d2_valid),
        .o_ready (w_d3_ready),
        .i_x     ({w_days, 2'b11}),
        .i_side  (w_sod),
        .o_valid (w_d3_valid),
        .i_ready (w_d4_ready),
        .o_q     (w_d3_q),
        .o_r     (w_d3_r),
        .o_side  (w_d3_side)
    );

    // Seconds of day into minutes and seconds.
    ucd_cdiv #(
        .XW(SOD_W), .QW(MINS_W), .SW(CENT_W + REM_W), .DIVISOR(SEC_PER_MIN)
    ) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d3_valid),
        .o_ready (w_d4_ready),
        .i_x     (w_d3_side),
        .i_side  ({w_d3_q, w_d3_r}),
        .o_valid (w_d4_valid),
        .i_ready (w_d5_ready),
        .o_q     (w_d4_q),
        .o_r     (w_d4_r),
        .o_side  (w_d4_side)
    );

    // Minutes of day into hours and minutes.
    ucd_cdiv #(
        .XW(MINS_W), .QW(HOUR_W), .SW(SEC_W + CENT_W + REM_W), .DIVISOR(SEC_PER_MIN)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d4_valid),
        .o_ready (w_d5_ready),
        .i_x     (w_d4_q),
        .i_side  ({w_d4_r, w_d4_side}),
        .o_valid (w_d5_valid),
        .i_ready (w_ce_b),
        .o_q     (w_d5_q),
        .o_r     (w_d5_r),
        .o_side  (w_d5_side)
    );

    // Stage B: year-of-century multiply on the day within the century.
    assign w_ce_b         = !r_vb || w_d6_ready;
    assign w_b_rem        = w_d5_side[REM_W-1:0] | REM_W'(3);
    assign n_py           = PY_W'(w_b_rem) * PY_W'(YEAR_MUL);
    assign n_b_tod.hour   = w_d5_q;
    assign n_b_tod.minute = w_d5_r;
    assign n_b_tod.second = w_d5_side[SEC_W+CENT_W+REM_W-1:CENT_W+REM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_ce_b) begin
            r_vb <= w_d5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce_b) begin
            r_py     <= n_py;
            r_b_cent <= w_d5_side[CENT_W+REM_W-1:REM_W];
            r_b_tod  <= n_b_tod;
        end
    end

    // March-based day of year from the low product word.
    assign w_d6_side_in.yoc  = r_py[YOC_W+31:32];
    assign w_d6_side_in.tod  = r_b_tod;
    assign w_d6_side_in.cent = r_b_cent;

    ucd_cdiv #(
        .XW(32), .QW(DOY_W), .SW($bits(t_y_side)), .DIVISOR(DOY_DIV)
    ) u_div_doy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vb),
        .o_ready (w_d6_ready),
        .i_x     (r_py[31:0]),
        .i_side  (w_d6_side_in),
        .o_valid (w_d6_valid),
        .i_ready (w_ce_c),
        .o_q     (w_d6_q),
        .o_r     (),
        .o_side  (w_d6_side)
    );

    // Stage C: shifted year and the month numerator.
    assign w_ce_c = !r_vc || w_d7_ready;
    assign n_c_jf = (w_d6_q >= MARCH_SPAN);
    assign n_c_ys = YEAR_W'(w_d6_side.cent) * CENT_YEARS + YEAR_W'(w_d6_side.yoc)
                    + YEAR_W'(n_c_jf);
    assign n_c_n4 = N4_W'(w_d6_q) * MONTH_MUL + MONTH_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_ce_c) begin
            r_vc <= w_d6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce_c) begin
            r_c_ys  <= n_c_ys;
            r_c_jf  <= n_c_jf;
            r_c_n4  <= n_c_n4;
            r_c_tod <= w_d6_side.tod;
        end
    end

    // Day of month from the low 16 bits of the month numerator.
    assign w_d7_side_in.year_shifted = r_c_ys;
    assign w_d7_side_in.jan_feb      = r_c_jf;
    assign w_d7_side_in.mon_m        = r_c_n4[N4_W-1:16];
    assign w_d7_side_in.tod          = r_c_tod;

    ucd_cdiv #(
        .XW(16), .QW(DAY_W), .SW($bits(t_m_side)), .DIVISOR(MONTH_DIV)
    ) u_div_dom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vc),
        .o_ready (w_d7_ready),
        .i_x     (r_c_n4[15:0]),
        .i_side  (w_d7_side_in),
        .o_valid (w_d7_valid),
        .i_ready (w_ce_o),
        .o_q     (w_d7_q),
        .o_r     (),
        .o_side  (w_d7_side)
    );

    // Output register: rebase the year, turn the March-based month into January-based.
    assign w_ce_o = !r_vo || i_m_axis_tready;
    assign n_year = w_d7_side.year_shifted - YEAR_BIAS;
    assign n_mon  = (w_d7_side.jan_feb ? (w_d7_side.mon_m - MONTHS_PER_YEAR)
                                       : w_d7_side.mon_m) - MON_W'(1);
    assign n_day  = w_d7_q + DAY_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_ce_o) begin
            r_vo <= w_d7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce_o) begin
            r_year  <= n_year;
            r_mon   <= n_mon;
            r_day   <= n_day;
            r_o_tod <= w_d7_side.tod;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {r_o_tod.second, r_o_tod.minute, r_o_tod.hour,
                              r_day, r_mon, r_year};

    `ASSERT_SYNC(a_month_range, i_clk, i_rst_n, r_vo |-> (r_mon < MONTHS_PER_YEAR))
    `ASSERT_SYNC(a_day_nonzero, i_clk, i_rst_n, r_vo |-> (r_day != '0))
    `ASSERT_SYNC(a_hour_range, i_clk, i_rst_n, r_vo |-> (r_o_tod.hour < HOURS_PER_DAY))

endmodule

`default_nettype wire
